/* rtl/vts_pkg.sv */
// Shared types, constants and helpers for the virtual timer scheduler.
`timescale 1ns / 1ps
package vts_pkg;

    localparam int NUM_TIMERS = 32;
    localparam int MAX_FIRES  = 64;
    localparam int IDX_W      = 5;
    localparam int CNT_W      = 6;
    localparam int FIRE_W     = 7;

    typedef enum logic [2:0] {
        OP_ACTIVATE   = 3'd0,
        OP_DEACTIVATE = 3'd1,
        OP_ADVANCE    = 3'd2,
        OP_QUERY      = 3'd3,
        OP_HARD_RESET = 3'd4
    } opcode_t;

    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_ACK   = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  timer_index;
        logic [63:0] delay_ns;
        logic [63:0] period_ns;
        logic        continuous;
        logic [31:0] advance_ns;
    } vts_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  fired_index;
        logic [63:0] time_ns;
        logic        last;
        logic        truncated;
    } vts_out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_EXEC,
        S_QRD,
        S_QOUT,
        S_SCAN,
        S_DECIDE,
        S_HR
    } vts_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic qout;
        logic adv_init;
        logic hr_init;
        logic scan_init;
        logic scan;
        logic hr;
        logic decide;
        logic ack;
    } vts_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       scan_done;
        logic       found;
        logic       full;
    } vts_stat_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

/* rtl/vts_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module vts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/vts_dp.sv */
// Datapath: timer storage, scan/compare unit, firing bookkeeping, result register.
`timescale 1ns / 1ps
module vts_dp import vts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  vts_in_t   item,
    input  logic      cfg_valid,
    input  logic [5:0] cfg_data,
    input  vts_cmd_t  cmd,
    output vts_stat_t stat,
    output logic      result_valid,
    output vts_out_t  result
);
    logic [CNT_W-1:0]      tc_reg, tc_next, n_eff;
    vts_in_t               item_reg;
    logic [63:0]           vt_reg, vt_next;
    logic [NUM_TIMERS-1:0] en_reg, en_next, per_reg, per_next;
    logic [NUM_TIMERS-1:0] dvld_reg, dvld_next, pvld_reg, pvld_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  rd_v_reg, rd_v_next;
    logic [IDX_W-1:0]      rd_idx_reg, raddr;
    logic                  best_found_reg, best_found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [63:0]           best_dl_reg, best_dl_next, best_pd_reg, best_pd_next;
    logic                  pend_reg, pend_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [63:0]           pend_dl_reg, pend_dl_next;
    logic [FIRE_W-1:0]     fire_cnt_reg, fire_cnt_next;
    logic                  res_v_reg, res_v_next;
    vts_out_t              res_reg, res_next;
    logic                  dl_we, pd_we;
    logic [IDX_W-1:0]      dl_waddr;
    logic [63:0]           dl_wdata, dl_q, pd_q, rd_dl, rd_pd, left;
    logic                  idx_ok;

    assign n_eff  = (tc_reg > CNT_W'(NUM_TIMERS)) ? CNT_W'(NUM_TIMERS) : tc_reg;
    assign idx_ok = {1'b0, item_reg.timer_index} < n_eff;
    assign raddr  = cmd.scan ? scan_cnt_reg[IDX_W-1:0] : item_reg.timer_index;
    assign rd_dl  = dvld_reg[rd_idx_reg] ? dl_q : 64'd0;
    assign rd_pd  = pvld_reg[rd_idx_reg] ? pd_q : 64'd0;
    assign left   = (idx_ok && en_reg[rd_idx_reg] && rd_dl >= vt_reg) ? rd_dl - vt_reg : 64'd0;

    vts_ram #(.WIDTH(64), .DEPTH(NUM_TIMERS)) u_dl_ram (
        .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
        .raddr(raddr), .rdata(dl_q)
    );

    vts_ram #(.WIDTH(64), .DEPTH(NUM_TIMERS)) u_pd_ram (
        .clk(clk), .we(pd_we), .waddr(item_reg.timer_index), .wdata(item_reg.period_ns),
        .raddr(raddr), .rdata(pd_q)
    );

    assign stat.op        = item_reg.opcode;
    assign stat.scan_done = (scan_cnt_reg == n_eff) && !rd_v_reg;
    assign stat.found     = best_found_reg;
    assign stat.full      = fire_cnt_reg == FIRE_W'(MAX_FIRES);

    always_comb
    begin
        tc_next         = cfg_valid ? cfg_data : tc_reg;
        vt_next         = vt_reg;
        en_next         = en_reg;
        per_next        = per_reg;
        dvld_next       = dvld_reg;
        pvld_next       = pvld_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_v_next       = 1'b0;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_dl_next    = best_dl_reg;
        best_pd_next    = best_pd_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        pend_dl_next    = pend_dl_reg;
        fire_cnt_next   = fire_cnt_reg;
        res_v_next      = 1'b0;
        res_next        = '{kind: KIND_ACK, fired_index: '0, time_ns: '0,
                            last: 1'b1, truncated: 1'b0};
        dl_we           = 1'b0;
        pd_we           = 1'b0;
        dl_waddr        = item_reg.timer_index;
        dl_wdata        = sat_add(vt_reg, item_reg.delay_ns);

        if (cmd.exec)
        begin
            res_v_next = 1'b1;
            if (idx_ok && item_reg.opcode == OP_ACTIVATE)
            begin
                dl_we = 1'b1;
                dvld_next[item_reg.timer_index] = 1'b1;
                en_next[item_reg.timer_index]   = 1'b1;
                per_next[item_reg.timer_index]  = item_reg.continuous;
                if (item_reg.period_ns != 64'd0)
                begin
                    pd_we = 1'b1;
                    pvld_next[item_reg.timer_index] = 1'b1;
                end
            end
            else if (idx_ok && item_reg.opcode == OP_DEACTIVATE)
            begin
                en_next[item_reg.timer_index] = 1'b0;
            end
        end

        if (cmd.qout)
        begin
            res_v_next = 1'b1;
            res_next   = '{kind: KIND_REPLY, fired_index: item_reg.timer_index,
                           time_ns: left, last: 1'b1, truncated: 1'b0};
        end

        if (cmd.ack)
        begin
            res_v_next = 1'b1;
        end

        if (cmd.adv_init)
        begin
            vt_next       = sat_add(vt_reg, {32'd0, item_reg.advance_ns});
            fire_cnt_next = '0;
            pend_next     = 1'b0;
        end

        if (cmd.hr_init)
        begin
            vt_next = '0;
        end

        if (cmd.scan)
        begin
            if (scan_cnt_reg < n_eff)
            begin
                rd_v_next     = 1'b1;
                scan_cnt_next = scan_cnt_reg + 1'b1;
            end
            if (rd_v_reg && cmd.hr)
            begin
                // rearm continuous timers at their period
                if (en_reg[rd_idx_reg] && per_reg[rd_idx_reg])
                begin
                    dl_we     = 1'b1;
                    dl_waddr  = rd_idx_reg;
                    dl_wdata  = rd_pd;
                    dvld_next[rd_idx_reg] = 1'b1;
                end
            end
            else if (rd_v_reg && en_reg[rd_idx_reg] && rd_dl <= vt_reg)
            begin
                // strict compare keeps the lowest index on equal deadlines
                if (!best_found_reg || rd_dl < best_dl_reg)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_dl_next    = rd_dl;
                    best_pd_next    = rd_pd;
                end
            end
        end

        if (cmd.decide)
        begin
            if (!best_found_reg)
            begin
                res_v_next = 1'b1;
                if (pend_reg)
                begin
                    res_next = '{kind: KIND_FIRED, fired_index: pend_idx_reg,
                                 time_ns: pend_dl_reg, last: 1'b1, truncated: 1'b0};
                end
            end
            else if (fire_cnt_reg == FIRE_W'(MAX_FIRES))
            begin
                res_v_next = 1'b1;
                res_next   = '{kind: KIND_FIRED, fired_index: pend_idx_reg,
                               time_ns: pend_dl_reg, last: 1'b1, truncated: 1'b1};
            end
            else
            begin
                if (pend_reg)
                begin
                    res_v_next = 1'b1;
                    res_next   = '{kind: KIND_FIRED, fired_index: pend_idx_reg,
                                   time_ns: pend_dl_reg, last: 1'b0, truncated: 1'b0};
                end
                pend_next     = 1'b1;
                pend_idx_next = best_idx_reg;
                pend_dl_next  = best_dl_reg;
                fire_cnt_next = fire_cnt_reg + 1'b1;
                if (per_reg[best_idx_reg])
                begin
                    dl_we    = 1'b1;
                    dl_waddr = best_idx_reg;
                    dl_wdata = sat_add(best_dl_reg, best_pd_reg);
                    dvld_next[best_idx_reg] = 1'b1;
                end
                else
                begin
                    en_next[best_idx_reg] = 1'b0;
                end
            end
        end

        if (cmd.scan_init)
        begin
            scan_cnt_next   = '0;
            best_found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg         <= CNT_W'(NUM_TIMERS);
            vt_reg         <= '0;
            en_reg         <= '0;
            per_reg        <= '0;
            dvld_reg       <= '0;
            pvld_reg       <= '0;
            scan_cnt_reg   <= '0;
            rd_v_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            pend_reg       <= 1'b0;
            fire_cnt_reg   <= '0;
            res_v_reg      <= 1'b0;
        end
        else
        begin
            tc_reg         <= tc_next;
            vt_reg         <= vt_next;
            en_reg         <= en_next;
            per_reg        <= per_next;
            dvld_reg       <= dvld_next;
            pvld_reg       <= pvld_next;
            scan_cnt_reg   <= scan_cnt_next;
            rd_v_reg       <= rd_v_next;
            best_found_reg <= best_found_next;
            pend_reg       <= pend_next;
            fire_cnt_reg   <= fire_cnt_next;
            res_v_reg      <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        rd_idx_reg   <= raddr;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        best_pd_reg  <= best_pd_next;
        pend_idx_reg <= pend_idx_next;
        pend_dl_reg  <= pend_dl_next;
        res_reg      <= res_next;
    end

    assign result_valid = res_v_reg;
    assign result       = res_reg;

`ifndef SYNTH
    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_W'(MAX_FIRES))
        else $error("fire count above limit");
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg && res_reg.truncated |-> res_reg.last && res_reg.kind == KIND_FIRED)
        else $error("truncated on a non-final result");
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg && res_reg.kind == KIND_ACK |-> res_reg.time_ns == 64'd0 && res_reg.last)
        else $error("malformed acknowledge");
`endif
endmodule

/* rtl/vts_ctrl.sv */
// Controller state machine sequencing the datapath per item.
`timescale 1ns / 1ps
module vts_ctrl import vts_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  vts_stat_t stat,
    output vts_cmd_t  cmd,
    output logic      busy
);
    vts_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (start) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (stat.op)
                    OP_ADVANCE:    state_next = S_SCAN;
                    OP_QUERY:      state_next = S_QRD;
                    OP_HARD_RESET: state_next = S_HR;
                    default:       state_next = S_EXEC;
                endcase
            end
            S_EXEC:     state_next = S_IDLE;
            S_QRD:      state_next = S_QOUT;
            S_QOUT:     state_next = S_IDLE;
            S_SCAN:     if (stat.scan_done) state_next = S_DECIDE;
            S_DECIDE:   state_next = (stat.found && !stat.full) ? S_SCAN : S_IDLE;
            S_HR:       if (stat.scan_done) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:     cmd.load = start;
            S_DISPATCH:
            begin
                cmd.adv_init  = stat.op == OP_ADVANCE;
                cmd.hr_init   = stat.op == OP_HARD_RESET;
                cmd.scan_init = stat.op == OP_ADVANCE || stat.op == OP_HARD_RESET;
            end
            S_EXEC:     cmd.exec = 1'b1;
            S_QRD:      cmd.load = 1'b0;
            S_QOUT:     cmd.qout = 1'b1;
            S_SCAN:     cmd.scan = 1'b1;
            S_DECIDE:
            begin
                cmd.decide    = 1'b1;
                cmd.scan_init = stat.found && !stat.full;
            end
            S_HR:
            begin
                cmd.scan = 1'b1;
                cmd.hr   = 1'b1;
                cmd.ack  = stat.scan_done;
            end
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

`ifndef SYNTH
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE && !busy)
        else $error("item latched while busy");
    a_decide_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DECIDE |-> $past(state_reg) == S_SCAN)
        else $error("decide without scan");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.exec, cmd.qout, cmd.decide, cmd.ack}))
        else $error("conflicting result commands");
`endif
endmodule

/* rtl/virtual_timer_scheduler_unit.sv */
// Top level of the virtual timer scheduler.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive item and raise start; the item is taken on an edge
//   where start is high and busy is low. Results come back on result, each
//   marked by result_valid for exactly one cycle; the receiver cannot stall,
//   so every result must be taken in the cycle it is shown.
//   Config channel: cfg_data (slot count) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Write only while idle.
// Operations:
//   activate/deactivate/unknown: answered with an acknowledge.
//   query: answered with a reply.
//   hard reset: one slot per cycle through the RAM port.
//   advance: each firing takes one full scan of the deadline RAM, one slot
//   per cycle, to find the earliest due.
//   Results of an advance leave at most one per scan, the final one flagged last.
// One item is in work at a time; busy stays high until its last result is
// registered. Reset clears time, all timers and sets the slot count to 32.
module virtual_timer_scheduler_unit import vts_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  vts_in_t    item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,
    output logic       result_valid,
    output vts_out_t   result
);
    vts_cmd_t  cmd;
    vts_stat_t stat;
    logic      cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    vts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
    );

    vts_dp u_dp (
        .clk(clk), .rst_n(rst_n), .item(item), .cfg_valid(cfg_we), .cfg_data(cfg_data),
        .cmd(cmd), .stat(stat), .result_valid(result_valid), .result(result)
    );
endmodule
